FILE: src/jpeg_marker_bit_depth_scan_assert.svh
// assertion macros shared by the marker scan modules
`ifndef JPEG_MARKER_BIT_DEPTH_SCAN_ASSERT_SVH
`define JPEG_MARKER_BIT_DEPTH_SCAN_ASSERT_SVH

// same-cycle implication, checked on clk, off during reset
`define JMBD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define JMBD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/jmbd_pkg.sv
// shared types, marker codes and code classifier for the marker scan
`default_nettype none

package jmbd_pkg;

	typedef enum logic [7:0] {
		PH_PREFIX    = 8'b0000_0001,
		PH_CODE      = 8'b0000_0010,
		PH_LEN_HI    = 8'b0000_0100,
		PH_LEN_LO    = 8'b0000_1000,
		PH_PRECISION = 8'b0001_0000,
		PH_SKIP      = 8'b0010_0000,
		PH_ERR_WAIT  = 8'b0100_0000,
		PH_DONE      = 8'b1000_0000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_FRAME,
		KIND_SEGMENT,
		KIND_STANDALONE,
		KIND_BAD
	} kind_t;

	typedef struct packed {
		logic [7:0] depth;
		logic [1:0] status;
	} result_t;

	localparam logic [1:0] ST_FOUND = 2'd0;
	localparam logic [1:0] ST_ERROR = 2'd1;
	localparam logic [1:0] ST_NONE  = 2'd2;

	localparam logic [7:0] MARK_PREFIX    = 8'hff;
	localparam logic [7:0] CODE_TEM       = 8'h01;
	localparam logic [7:0] CODE_RES_FIRST = 8'h03;
	localparam logic [7:0] CODE_RES_LAST  = 8'hbf;
	localparam logic [7:0] CODE_SOF0      = 8'hc0;
	localparam logic [7:0] CODE_SOF3      = 8'hc3;
	localparam logic [7:0] CODE_DHT       = 8'hc4;
	localparam logic [7:0] CODE_SOF5      = 8'hc5;
	localparam logic [7:0] CODE_SOF7      = 8'hc7;
	localparam logic [7:0] CODE_JPG       = 8'hc8;
	localparam logic [7:0] CODE_SOF9      = 8'hc9;
	localparam logic [7:0] CODE_SOF11     = 8'hcb;
	localparam logic [7:0] CODE_DAC       = 8'hcc;
	localparam logic [7:0] CODE_SOF13     = 8'hcd;
	localparam logic [7:0] CODE_SOF15     = 8'hcf;
	localparam logic [7:0] CODE_RST_FIRST = 8'hd0;
	localparam logic [7:0] CODE_EOI       = 8'hd9;
	localparam logic [7:0] CODE_SOS       = 8'hda;
	localparam logic [7:0] CODE_COM       = 8'hfe;

	// bytes still needed before a syntax error is reported
	localparam logic [15:0] ERR_WAIT_PREFIX = 16'd4;
	localparam logic [15:0] ERR_WAIT_CODE   = 16'd3;
	localparam logic [15:0] ERR_WAIT_LEN    = 16'd1;

	localparam logic [15:0] SEG_LEN_BARE = 16'd2;

	// result queue depth
	localparam logic [1:0] OUTQ_FULL = 2'd2;

	function automatic kind_t classify(input logic [7:0] code);
		kind_t kind;
		unique case (code) inside
			[CODE_SOF0:CODE_SOF3], [CODE_SOF5:CODE_SOF7],
			[CODE_SOF9:CODE_SOF11], [CODE_SOF13:CODE_SOF15]: kind = KIND_FRAME;
			CODE_DHT, CODE_JPG, CODE_DAC, [CODE_SOS:CODE_COM]: kind = KIND_SEGMENT;
			[CODE_RST_FIRST:CODE_EOI], CODE_TEM,
			[CODE_RES_FIRST:CODE_RES_LAST]: kind = KIND_STANDALONE;
			default: kind = KIND_BAD;
		endcase
		return kind;
	endfunction

endpackage

`default_nettype wire

FILE: src/jmbd_parse.sv
// marker walker: phase state machine, segment skip counter and result decision
`default_nettype none

`include "jpeg_marker_bit_depth_scan_assert.svh"

module jmbd_parse (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                step,
	input  wire  [7:0]         data_byte,
	input  wire                last_byte,
	output logic               emit,
	output jmbd_pkg::result_t  result
);
	import jmbd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [15:0] skip_q, skip_d;
	logic [7:0]  len_hi_q, len_hi_d;
	logic        frame_q, frame_d;

	kind_t       kind;
	logic [15:0] seg_len;
	logic [15:0] skip_dec;
	logic        decided;

	assign kind     = classify(data_byte);
	assign seg_len  = {len_hi_q, data_byte};
	assign skip_dec = (skip_q != 16'd0) ? (skip_q - 16'd1) : skip_q;

	always_comb begin
		phase_d  = phase_q;
		skip_d   = skip_q;
		len_hi_d = len_hi_q;
		frame_d  = frame_q;
		decided  = 1'b0;
		emit     = 1'b0;
		result   = '{depth: 8'h00, status: ST_NONE};
		if (step) begin
			unique case (phase_q)
				PH_PREFIX: begin
					if (data_byte == MARK_PREFIX) begin
						phase_d = PH_CODE;
					end else begin
						phase_d = PH_ERR_WAIT;
						skip_d  = ERR_WAIT_PREFIX;
					end
				end
				PH_CODE: begin
					if (kind == KIND_FRAME || kind == KIND_SEGMENT) begin
						frame_d = (kind == KIND_FRAME);
						phase_d = PH_LEN_HI;
					end else if (kind == KIND_STANDALONE) begin
						phase_d = PH_PREFIX;
					end else begin
						phase_d = PH_ERR_WAIT;
						skip_d  = ERR_WAIT_CODE;
					end
				end
				PH_LEN_HI: begin
					len_hi_d = data_byte;
					phase_d  = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					if (frame_q) begin
						phase_d = PH_PRECISION;
					end else if (seg_len < SEG_LEN_BARE) begin
						phase_d = PH_ERR_WAIT;
						skip_d  = ERR_WAIT_LEN;
					end else if (seg_len == SEG_LEN_BARE) begin
						phase_d = PH_PREFIX;
					end else begin
						skip_d  = seg_len - SEG_LEN_BARE;
						phase_d = PH_SKIP;
					end
				end
				PH_PRECISION: begin
					decided = 1'b1;
					result  = '{depth: data_byte, status: ST_FOUND};
					phase_d = PH_DONE;
				end
				PH_SKIP: begin
					skip_d = skip_dec;
					if (skip_dec == 16'd0) begin
						phase_d = PH_PREFIX;
					end
				end
				PH_ERR_WAIT: begin
					skip_d = skip_dec;
					if (skip_dec == 16'd0) begin
						decided = 1'b1;
						result  = '{depth: 8'h00, status: ST_ERROR};
						phase_d = PH_DONE;
					end
				end
				PH_DONE: begin
					phase_d = PH_DONE;
				end
				default: begin
					phase_d = PH_PREFIX;
				end
			endcase
			emit = decided;
			// fragment ends with no answer yet
			if (last_byte && !decided && phase_q != PH_DONE) begin
				emit   = 1'b1;
				result = '{depth: 8'h00, status: ST_NONE};
			end
			if (last_byte) begin
				phase_d  = PH_PREFIX;
				skip_d   = 16'd0;
				len_hi_d = 8'h00;
				frame_d  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_PREFIX;
			skip_q   <= 16'd0;
			len_hi_q <= 8'h00;
			frame_q  <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			skip_q   <= skip_d;
			len_hi_q <= len_hi_d;
			frame_q  <= frame_d;
		end
	end

	`JMBD_ASSERT_NOW(a_found_from_precision, emit && result.status == ST_FOUND,
		phase_q == PH_PRECISION, "found result outside precision phase")
	`JMBD_ASSERT_NOW(a_no_second_answer, step && phase_q == PH_DONE, !emit,
		"second result in one fragment")
	`JMBD_ASSERT_NEXT(a_last_clears, step && last_byte,
		phase_q == PH_PREFIX && skip_q == 16'd0 && !frame_q,
		"state not cleared after last byte")

endmodule

`default_nettype wire

FILE: src/jmbd_outq.sv
// two-entry result queue: output register plus skid entry
`default_nettype none

`include "jpeg_marker_bit_depth_scan_assert.svh"

module jmbd_outq (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  jmbd_pkg::result_t  push_data,
	output logic               full,
	output logic               out_valid,
	input  wire                out_stall,
	output jmbd_pkg::result_t  head
);
	import jmbd_pkg::*;

	result_t    head_q;
	result_t    skid_q;
	logic [1:0] cnt_q;
	logic       pop;
	logic       wr_head;

	assign out_valid = (cnt_q != 2'd0);
	assign full      = (cnt_q == OUTQ_FULL);
	assign head      = head_q;
	assign pop       = out_valid && !out_stall;
	assign wr_head   = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

	always_ff @(posedge clk) begin
		if (push && wr_head) begin
			head_q <= push_data;
		end else if (pop) begin
			head_q <= skid_q;
		end
		if (push && !wr_head) begin
			skid_q <= push_data;
		end
	end

	`JMBD_ASSERT_NOW(a_no_push_when_full, push, !full, "result pushed into full queue")
	`JMBD_ASSERT_NEXT(a_empty_push_shows, push && cnt_q == 2'd0,
		out_valid && head_q == $past(push_data), "pushed result not at head")
	`JMBD_ASSERT_NEXT(a_pop_moves_skid, pop && !push && full,
		cnt_q == 2'd1 && head_q == $past(skid_q), "skid entry not moved to head")

endmodule

`default_nettype wire

FILE: src/jpeg_marker_bit_depth_scan.sv
// top level: byte input register, marker walker and result queue
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------
//  in      | in_valid / in_stall  | data_byte, last_byte
//  out     | out_valid / out_stall| bit_depth, scan_status
//
// one byte per cycle unless in_stall holds it; a result is registered into the queue
// the byte register feeds the walker, which decides combinationally into the queue
// the two-entry queue keeps bytes flowing while a result waits at the output
// in_stall rises only when a byte is held and the queue is full
// arst_n clears the valid flags, queue count and parser state
`default_nettype none

module jpeg_marker_bit_depth_scan (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [7:0]  data_byte,
	input  wire         last_byte,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [7:0]  bit_depth,
	output logic [1:0]  scan_status
);
	import jmbd_pkg::*;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       full;
	logic       step;
	logic       emit;
	result_t    result;
	result_t    head;

	assign in_stall = valid_s1 && full;
	assign step     = valid_s1 && !full;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	jmbd_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.emit      (emit),
		.result    (result)
	);

	jmbd_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit),
		.push_data (result),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign bit_depth   = head.depth;
	assign scan_status = head.status;

endmodule

`default_nettype wire
